@@ src/bia_pkg.sv @@
// Shared types and constants for the box IoU table block.
`default_nettype none
package bia_pkg;

  localparam int COORD_W        = 13;
  localparam int CMD_W          = 2;
  localparam int IDX_W          = 6;
  localparam int OVL_W          = 27;
  localparam int IOU_W          = 17;
  localparam int RESULT_CAP     = 64;
  localparam int NCNT_W         = 7;
  localparam int EXT_W          = COORD_W + 2;
  localparam int AREA_W         = 2 * EXT_W;
  localparam int INTER_W        = 2 * (COORD_W + 1);
  localparam int UNI_W          = AREA_W + 2;
  localparam int DEN_W          = UNI_W - 1;
  localparam int DIV_STEPS      = IOU_W;
  localparam int DIV_CNT_W      = 5;
  localparam int ONE_Q16        = 65536;
  localparam int AREA_MAX       = 134217727;
  localparam int DEF_MAX_REF    = 64;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } box_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] ref_index;
    logic [OVL_W-1:0] overlap_area;
    logic [IOU_W-1:0] iou;
    logic             last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AREA,
    S_LOAD,
    S_MUL,
    S_UNION,
    S_DIVSET,
    S_DIV,
    S_OUT
  } state_e;

endpackage
`default_nettype wire

@@ src/bia_ref_mem.sv @@
// Reference box store: one write port, one registered read port.
`default_nettype none
module bia_ref_mem #(
  parameter int DEPTH = bia_pkg::DEF_MAX_REF,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire bia_pkg::box_t wdata,
  input  wire logic [AW-1:0] raddr,
  output bia_pkg::box_t      rdata
);

  bia_pkg::box_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/bia_div.sv @@
// Restoring divider producing one quotient bit per cycle for the Q1.16 ratio.
`default_nettype none
module bia_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [bia_pkg::INTER_W-1:0]   num,
  input  wire logic [bia_pkg::DEN_W-1:0]     den,
  output logic                               done,
  output logic [bia_pkg::IOU_W-1:0]          quot
);

  logic                               busy;
  logic                               first;
  logic [bia_pkg::DIV_CNT_W-1:0]      cnt;
  logic [bia_pkg::DEN_W-1:0]          rem;
  logic [bia_pkg::DEN_W-1:0]          dreg;
  logic [bia_pkg::DEN_W-1:0]          trial;
  logic                               qbit;

  always_comb begin
    trial = first ? rem : {rem[bia_pkg::DEN_W-2:0], 1'b0};
    qbit  = (trial >= dreg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == bia_pkg::DIV_CNT_W'(bia_pkg::DIV_STEPS - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= bia_pkg::DEN_W'(num);
      dreg  <= den;
      first <= 1'b1;
      cnt   <= '0;
      quot  <= '0;
    end else if (busy) begin
      rem   <= qbit ? (trial - dreg) : trial;
      first <= 1'b0;
      cnt   <= cnt + 1'b1;
      quot  <= {quot[bia_pkg::IOU_W-2:0], qbit};
    end
  end

endmodule
`default_nettype wire

@@ src/box_iou_all_pairs.sv @@
// Top level: reference box table with IoU query against every stored box.
// Clear and append are taken in the idle state; the block stays idle and ready afterwards.
// A query yields one result per stored box (up to 64 boxes), each waiting on the one-bit-per-cycle divider
// for its 17 quotient bits unless the IoU is zero or saturated, and then on output stall time.
// One box is processed at a time; req_ready is low until the last word is taken.
// Synchronous reset empties the table; stored entries are not cleared.
`default_nettype none
module box_iou_all_pairs #(
  parameter int MAX_REF    = bia_pkg::DEF_MAX_REF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   req_valid,
  output logic        req_ready,
  input  wire bia_pkg::req_t req,
  output logic        rsp_valid,
  input  wire logic   rsp_ready,
  output bia_pkg::rsp_t rsp
);

  localparam int AW     = (MAX_REF > 1) ? $clog2(MAX_REF) : 1;
  localparam int CW     = $clog2(MAX_REF + 1);

  bia_pkg::state_e state, state_next;

  logic [CW-1:0]                      count;
  logic [bia_pkg::NCNT_W-1:0]         n;
  logic [bia_pkg::IDX_W-1:0]          idx;
  bia_pkg::box_t                      qbox;
  bia_pkg::box_t                      rd;
  bia_pkg::box_t                      in_box;
  logic [bia_pkg::COORD_W:0]          w_c, h_c;
  logic signed [bia_pkg::EXT_W-1:0]   bw, bh, qw, qh, wx, hy;
  logic signed [bia_pkg::AREA_W-1:0]  area_a, area_b;
  logic [bia_pkg::INTER_W-1:0]        inter;
  logic signed [bia_pkg::UNI_W-1:0]   uni;
  logic [bia_pkg::OVL_W-1:0]          ov;
  logic [bia_pkg::IOU_W-1:0]          iou;
  logic [bia_pkg::COORD_W-1:0]        min_r, max_l, min_b, max_t;
  logic                               acc, we, room, uni_pos, sat, last;
  logic                               div_start, div_done;
  logic [bia_pkg::IOU_W-1:0]          quot;

  assign in_box.left   = req.left;
  assign in_box.top    = req.top;
  assign in_box.right  = req.right;
  assign in_box.bottom = req.bottom;

  assign acc  = req_valid && req_ready;
  assign room = (32'(count) < MAX_REF);
  assign we   = acc && (req.cmd == bia_pkg::CMD_APPEND) && room;
  assign last = ((bia_pkg::NCNT_W'(idx) + 1'b1) == n);

  bia_ref_mem #(.DEPTH(MAX_REF), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(count)),
    .wdata (in_box),
    .raddr (AW'(idx)),
    .rdata (rd)
  );

  bia_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (inter),
    .den   (uni[bia_pkg::DEN_W-1:0]),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    qw    = $signed({2'b0, qbox.right}) - $signed({2'b0, qbox.left}) + 15'sd1;
    qh    = $signed({2'b0, qbox.bottom}) - $signed({2'b0, qbox.top}) + 15'sd1;
    bw    = $signed({2'b0, rd.right}) - $signed({2'b0, rd.left}) + 15'sd1;
    bh    = $signed({2'b0, rd.bottom}) - $signed({2'b0, rd.top}) + 15'sd1;
    min_r = (qbox.right < rd.right) ? qbox.right : rd.right;
    max_l = (qbox.left > rd.left) ? qbox.left : rd.left;
    min_b = (qbox.bottom < rd.bottom) ? qbox.bottom : rd.bottom;
    max_t = (qbox.top > rd.top) ? qbox.top : rd.top;
    wx    = $signed({2'b0, min_r}) - $signed({2'b0, max_l}) + 15'sd1;
    hy    = $signed({2'b0, min_b}) - $signed({2'b0, max_t}) + 15'sd1;
    uni_pos = !uni[bia_pkg::UNI_W-1] && (uni != '0);
    sat     = ({4'b0, inter} >= {uni[bia_pkg::UNI_W-2:0], 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bia_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    div_start  = 1'b0;
    case (state)
      bia_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid && (req.cmd == bia_pkg::CMD_QUERY) && (count != '0)) begin
          state_next = bia_pkg::S_AREA;
        end
      end
      bia_pkg::S_AREA:   state_next = bia_pkg::S_LOAD;
      bia_pkg::S_LOAD:   state_next = bia_pkg::S_MUL;
      bia_pkg::S_MUL:    state_next = bia_pkg::S_UNION;
      bia_pkg::S_UNION:  state_next = bia_pkg::S_DIVSET;
      bia_pkg::S_DIVSET: begin
        if (!uni_pos || sat) begin
          state_next = bia_pkg::S_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = bia_pkg::S_DIV;
        end
      end
      bia_pkg::S_DIV: begin
        if (div_done) begin
          state_next = bia_pkg::S_OUT;
        end
      end
      bia_pkg::S_OUT: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = last ? bia_pkg::S_IDLE : bia_pkg::S_AREA;
        end
      end
      default: state_next = bia_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (acc && (req.cmd == bia_pkg::CMD_CLEAR)) begin
      count <= '0;
    end else if (we) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bia_pkg::S_IDLE: begin
        qbox <= in_box;
        idx  <= '0;
        n    <= (32'(count) >= bia_pkg::RESULT_CAP) ? bia_pkg::NCNT_W'(bia_pkg::RESULT_CAP)
                                                   : bia_pkg::NCNT_W'(count);
      end
      bia_pkg::S_AREA: begin
        area_a <= qw * qh;
      end
      bia_pkg::S_LOAD: begin
        w_c <= wx[bia_pkg::EXT_W-1] ? '0 : wx[bia_pkg::COORD_W:0];
        h_c <= hy[bia_pkg::EXT_W-1] ? '0 : hy[bia_pkg::COORD_W:0];
      end
      bia_pkg::S_MUL: begin
        area_b <= bw * bh;
        inter  <= w_c * h_c;
      end
      bia_pkg::S_UNION: begin
        uni <= bia_pkg::UNI_W'(area_a) + bia_pkg::UNI_W'(area_b)
             - $signed({2'b0, inter});
        ov  <= (32'(inter) > bia_pkg::AREA_MAX) ? bia_pkg::OVL_W'(bia_pkg::AREA_MAX)
                                                : inter[bia_pkg::OVL_W-1:0];
      end
      bia_pkg::S_DIVSET: begin
        if (!uni_pos) begin
          iou <= '0;
        end else if (sat) begin
          iou <= bia_pkg::IOU_W'(bia_pkg::ONE_Q16);
        end
      end
      bia_pkg::S_DIV: begin
        if (div_done) begin
          iou <= (32'(quot) > bia_pkg::ONE_Q16) ? bia_pkg::IOU_W'(bia_pkg::ONE_Q16) : quot;
        end
      end
      bia_pkg::S_OUT: begin
        if (rsp_ready && !last) begin
          idx <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign rsp.ref_index    = idx;
  assign rsp.overlap_area = ov;
  assign rsp.iou          = iou;
  assign rsp.last         = last;

endmodule
`default_nettype wire

@@ src/bia_checker.sv @@
// Port-level checks for the box IoU table block and their binding.
`default_nettype none
module bia_checker (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    req_valid,
  input wire logic    req_ready,
  input wire logic    rsp_valid,
  input wire logic    rsp_ready,
  input wire bia_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("input taken while a result is pending");

  a_iou_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(rsp.iou) <= bia_pkg::ONE_Q16))
    else $error("iou above one");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result after reset");

endmodule

bind box_iou_all_pairs bia_checker u_bia_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
`default_nettype wire
